FILE: sv/rhsv_pkg.sv
// shared constants, types and register map of the rainbow frame generator
package rhsv_pkg;

	localparam int LED_COUNT         = 25;
	localparam int HUE_FRACTION_BITS = 8;

	// hue in units of 2^-HUE_FRACTION_BITS degree
	localparam int HUE_FULL = 360 << HUE_FRACTION_BITS;
	localparam int HUE_SECT = 60 << HUE_FRACTION_BITS;
	localparam int HUE_W    = $clog2(HUE_FULL);
	localparam int T_W      = $clog2(HUE_SECT + 1);

	localparam int IDX_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int FRAC_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	// per-led hue spread split into whole part and remainder
	localparam int SPREAD_Q = HUE_FULL / LED_COUNT;
	localparam int SPREAD_R = HUE_FULL % LED_COUNT;

	localparam int STEP_W = 17;
	localparam int PIX_W  = 5;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// floor(y/60) as (y*DIV60_MUL) >> DIV60_SH, exact for y below 23831
	localparam int DIV60_SH  = 20;
	localparam int DIV60_MUL = ((1 << DIV60_SH) + 59) / 60;
	localparam int DIV60_W   = $clog2(DIV60_MUL + 1);

	localparam int P_W = 8 + T_W;
	localparam int Y_W = P_W - HUE_FRACTION_BITS;

	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_SATURATION = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_HUE_STEP   = 2'd2;

	localparam logic [7:0]        SATURATION_RST = 8'd255;
	localparam logic [7:0]        BRIGHTNESS_RST = 8'd77;
	localparam logic [STEP_W-1:0] HUE_STEP_RST   = 17'd768;

	typedef struct packed {
		logic [7:0]        saturation;
		logic [7:0]        brightness;
		logic [STEP_W-1:0] hue_step;
	} cfg_t;

	typedef struct packed {
		logic             load;
		logic             issue;
		logic             last;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic advance;
	} status_t;

endpackage

FILE: sv/rhsv_regs.sv
// configuration register file behind the apb port
module rhsv_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rhsv_pkg::ADDR_W-1:0] paddr,
	input  logic [rhsv_pkg::DATA_W-1:0] pwdata,
	output logic [rhsv_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output rhsv_pkg::cfg_t             cfg
);
	import rhsv_pkg::*;

	cfg_t                 cfg_q;
	logic                 wr;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr      = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.saturation <= SATURATION_RST;
			cfg_q.brightness <= BRIGHTNESS_RST;
			cfg_q.hue_step   <= HUE_STEP_RST;
		end else if (wr) begin
			case (reg_idx)
				REG_SATURATION: cfg_q.saturation <= pwdata[7:0];
				REG_BRIGHTNESS: cfg_q.brightness <= pwdata[7:0];
				REG_HUE_STEP:   cfg_q.hue_step   <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SATURATION: prdata = DATA_W'(cfg_q.saturation);
			REG_BRIGHTNESS: prdata = DATA_W'(cfg_q.brightness);
			REG_HUE_STEP:   prdata = DATA_W'(cfg_q.hue_step);
			default:        prdata = '0;
		endcase
	end

endmodule

FILE: sv/rhsv_ctrl.sv
// frame controller: takes requests and issues one pixel per cycle while the datapath advances
module rhsv_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                frame_request,
	output rhsv_pkg::cmd_t      cmd,
	input  rhsv_pkg::status_t   sts
);
	import rhsv_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic             state_q;
	logic [IDX_W-1:0] cnt_q;
	logic             start;
	logic             last;

	assign in_ready = (state_q == ST_IDLE);
	assign start    = in_valid & in_ready & frame_request;
	assign last     = (cnt_q == IDX_W'(LED_COUNT - 1));

	assign cmd.load  = start;
	assign cmd.issue = (state_q == ST_RUN);
	assign cmd.last  = last;
	assign cmd.idx   = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					if (sts.advance) begin
						cnt_q <= cnt_q + 1'b1;
						if (last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/rhsv_dp.sv
// hue generator and hsv to rgb pipeline
module rhsv_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rhsv_pkg::cfg_t            cfg,
	input  rhsv_pkg::cmd_t            cmd,
	output rhsv_pkg::status_t         sts,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rhsv_pkg::PIX_W-1:0] pixel_index,
	output logic [7:0]                red,
	output logic [7:0]                green,
	output logic [7:0]                blue,
	output logic                      last_pixel
);
	import rhsv_pkg::*;

	localparam logic [2:0] SEC_0 = 3'd0;
	localparam logic [2:0] SEC_1 = 3'd1;
	localparam logic [2:0] SEC_2 = 3'd2;
	localparam logic [2:0] SEC_3 = 3'd3;
	localparam logic [2:0] SEC_4 = 3'd4;
	localparam logic [2:0] SEC_5 = 3'd5;

	localparam logic [HUE_W:0] FULL_X = (HUE_W+1)'(HUE_FULL);
	localparam logic [HUE_W:0] S1 = (HUE_W+1)'(HUE_SECT);
	localparam logic [HUE_W:0] S2 = (HUE_W+1)'(2 * HUE_SECT);
	localparam logic [HUE_W:0] S3 = (HUE_W+1)'(3 * HUE_SECT);
	localparam logic [HUE_W:0] S4 = (HUE_W+1)'(4 * HUE_SECT);
	localparam logic [HUE_W:0] S5 = (HUE_W+1)'(5 * HUE_SECT);

	logic             adv;
	logic             fire;

	logic [HUE_W-1:0] offset_q;
	logic [HUE_W-1:0] hue_q;
	logic [FRAC_W-1:0] frac_q;
	logic [7:0]       c_q;

	logic [FRAC_W:0]  frac_sum;
	logic             carry;
	logic [HUE_W:0]   hue_sum;
	logic [HUE_W:0]   step_x;
	logic [HUE_W:0]   step_mod;
	logic [HUE_W:0]   off_sum;
	logic [15:0]      vs;
	logic [16:0]      vs_adj;

	logic [HUE_W:0]   h;
	logic [2:0]       sector;
	logic [HUE_W:0]   rem;
	logic [HUE_W:0]   sect_dist;
	logic [HUE_W:0]   t_full;

	logic             valid_s1, valid_s2, valid_s3;
	logic [2:0]       sector_s1, sector_s2, sector_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic             last_s1, last_s2, last_s3;
	logic [T_W-1:0]   t_s1;
	logic [P_W-1:0]   p_s2;
	logic [7:0]       x_s3;

	logic [Y_W-1:0]   y;
	logic [Y_W+DIV60_W-1:0] q_prod;

	logic [7:0]       m;
	logic [7:0]       r1, g1, b1;
	logic             out_valid_q;

	// whole pipeline moves when the output register is free or being emptied
	assign adv         = !out_valid_q || out_ready;
	assign sts.advance = adv;
	assign fire        = cmd.issue & adv;

	// running hue: offset plus floor(i*full/leds), kept as whole and remainder
	assign frac_sum = (FRAC_W+1)'(frac_q) + (FRAC_W+1)'(SPREAD_R);
	assign carry    = (frac_sum >= (FRAC_W+1)'(LED_COUNT));
	assign hue_sum  = (HUE_W+1)'(hue_q) + (HUE_W+1)'(SPREAD_Q) + (HUE_W+1)'(carry);

	assign step_x   = (HUE_W+1)'(cfg.hue_step);
	assign step_mod = (step_x >= FULL_X) ? (step_x - FULL_X) : step_x;
	assign off_sum  = (HUE_W+1)'(offset_q) + step_mod;

	// v*s/255 exact for 16-bit products
	assign vs     = cfg.brightness * cfg.saturation;
	assign vs_adj = 17'(vs) + 17'(vs >> 8) + 17'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (fire && cmd.last) begin
			offset_q <= (off_sum >= FULL_X) ? HUE_W'(off_sum - FULL_X) : HUE_W'(off_sum);
		end
	end

	always_ff @(posedge clk) begin
		c_q <= vs_adj[15:8];
		if (cmd.load) begin
			hue_q  <= offset_q;
			frac_q <= '0;
		end else if (fire) begin
			hue_q  <= (hue_sum >= FULL_X) ? HUE_W'(hue_sum - FULL_X) : HUE_W'(hue_sum);
			frac_q <= carry ? FRAC_W'(frac_sum - (FRAC_W+1)'(LED_COUNT)) : FRAC_W'(frac_sum);
		end
	end

	// sector and distance from the sector edge
	assign h = (HUE_W+1)'(hue_q);

	always_comb begin
		if (h >= S5)      sector = SEC_5;
		else if (h >= S4) sector = SEC_4;
		else if (h >= S3) sector = SEC_3;
		else if (h >= S2) sector = SEC_2;
		else if (h >= S1) sector = SEC_1;
		else              sector = SEC_0;
	end

	assign rem       = (h >= S4) ? (h - S4) : ((h >= S2) ? (h - S2) : h);
	assign sect_dist = (rem >= S1) ? (rem - S1) : (S1 - rem);
	assign t_full    = S1 - sect_dist;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= cmd.issue;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// x = floor(c*t/sect) = floor(floor(c*t >> frac)/60)
	assign y      = p_s2[P_W-1:HUE_FRACTION_BITS];
	assign q_prod = y * DIV60_W'(DIV60_MUL);

	always_ff @(posedge clk) begin
		if (adv) begin
			sector_s1 <= sector;
			t_s1      <= T_W'(t_full);
			idx_s1    <= cmd.idx;
			last_s1   <= cmd.last;

			sector_s2 <= sector_s1;
			p_s2      <= c_q * t_s1;
			idx_s2    <= idx_s1;
			last_s2   <= last_s1;

			sector_s3 <= sector_s2;
			x_s3      <= 8'(q_prod >> DIV60_SH);
			idx_s3    <= idx_s2;
			last_s3   <= last_s2;
		end
	end

	assign m = cfg.brightness - c_q;

	always_comb begin
		case (sector_s3)
			SEC_0:   begin r1 = c_q;  g1 = x_s3; b1 = 8'd0; end
			SEC_1:   begin r1 = x_s3; g1 = c_q;  b1 = 8'd0; end
			SEC_2:   begin r1 = 8'd0; g1 = c_q;  b1 = x_s3; end
			SEC_3:   begin r1 = 8'd0; g1 = x_s3; b1 = c_q;  end
			SEC_4:   begin r1 = x_s3; g1 = 8'd0; b1 = c_q;  end
			default: begin r1 = c_q;  g1 = 8'd0; b1 = x_s3; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_index <= PIX_W'(idx_s3);
			red         <= r1 + m;
			green       <= g1 + m;
			blue        <= b1 + m;
			last_pixel  <= last_s3;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: sv/rainbow_hsv_led_frame_generator_unit.sv
// Rainbow frame generator. Each accepted word with frame_request high produces
// LED_COUNT pixel words in strip order, one per cycle while out_ready stays high.
// The controller loads the frame's starting hue, then issues one pixel each time
// the pipeline advances; each pixel passes the hue sector, c*t multiply,
// divide-by-60 multiply and output register stages. A word with frame_request
// low is taken and produces nothing. The hue offset advances by hue_step once
// per frame. Registers (apb, byte address 4*i): 0 saturation, 1 brightness,
// 2 hue_step; write them only while no frame is in flight.
module rainbow_hsv_led_frame_generator_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rhsv_pkg::ADDR_W-1:0] paddr,
	input  logic [rhsv_pkg::DATA_W-1:0] pwdata,
	output logic [rhsv_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       frame_request,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rhsv_pkg::PIX_W-1:0]  pixel_index,
	output logic [7:0]                 red,
	output logic [7:0]                 green,
	output logic [7:0]                 blue,
	output logic                       last_pixel
);
	import rhsv_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t sts;

	rhsv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rhsv_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.frame_request (frame_request),
		.cmd           (cmd),
		.sts           (sts)
	);

	rhsv_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last_pixel  (last_pixel)
	);

endmodule

FILE: sv/rhsv_chk.sv
// port-level checks for the rainbow frame generator
module rhsv_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       frame_request,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [rhsv_pkg::PIX_W-1:0]  pixel_index,
	input logic [7:0]                 red,
	input logic [7:0]                 green,
	input logic [7:0]                 blue,
	input logic                       last_pixel
);
	import rhsv_pkg::*;

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_index) && $stable(red)
			&& $stable(green) && $stable(blue) && $stable(last_pixel))
		else $error("output word changed while stalled");

	// the frame ends on the last led
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_pixel |-> pixel_index == PIX_W'(LED_COUNT - 1))
		else $error("last pixel flag on wrong led");

	// pixels inside a frame come back to back
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_pixel |=> out_valid)
		else $error("gap inside a frame");

	// a frame request keeps the input side busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && frame_request |=> !in_ready)
		else $error("request taken while a frame is issuing");

endmodule

bind rainbow_hsv_led_frame_generator_unit rhsv_chk u_chk (.*);

FILE: bench/rainbow_frame_sb_pkg.sv
// scoreboard class with the rainbow pixel predictor for the frame generator bench
`timescale 1ns / 1ps

package rainbow_frame_sb_pkg;
	import rhsv_pkg::*;

	typedef struct {
		int unsigned idx;
		int unsigned red;
		int unsigned green;
		int unsigned blue;
		int unsigned last;
	} pixel_word_t;

	class rainbow_frame_scoreboard;
		pixel_word_t expected_pixels[$];
		int unsigned saturation;
		int unsigned brightness;
		int unsigned hue_step;
		int unsigned frame_hue;
		int unsigned mismatch_count;
		int unsigned pixels_checked;
		int unsigned frames_noted;
		int unsigned idle_words;

		function new();
			saturation     = SATURATION_RST;
			brightness     = BRIGHTNESS_RST;
			hue_step       = HUE_STEP_RST;
			frame_hue      = 0;
			mismatch_count = 0;
			pixels_checked = 0;
			frames_noted   = 0;
			idle_words     = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
			case (idx)
				REG_SATURATION: saturation = value[7:0];
				REG_BRIGHTNESS: brightness = value[7:0];
				REG_HUE_STEP:   hue_step   = value[STEP_W-1:0];
				default: ;
			endcase
		endfunction

		// one accepted word: a request queues a full frame of pixels, then moves the offset
		function void note_word(logic request);
			int unsigned led;
			int unsigned hue;
			int unsigned chroma;
			int unsigned rem;
			int unsigned fold;
			int unsigned x;
			int unsigned m;
			int unsigned r;
			int unsigned g;
			int unsigned b;
			pixel_word_t px;
			if (!request) begin
				idle_words++;
				return;
			end
			chroma = brightness * saturation / 255;
			m      = brightness - chroma;
			for (led = 0; led < LED_COUNT; led++) begin
				hue  = (led * HUE_FULL / LED_COUNT + frame_hue) % HUE_FULL;
				rem  = hue % (2 * HUE_SECT);
				fold = (rem >= HUE_SECT) ? rem - HUE_SECT : HUE_SECT - rem;
				x    = chroma * (HUE_SECT - fold) / HUE_SECT;
				// sector order red, yellow, green, cyan, blue, magenta
				case (hue / HUE_SECT)
					0: begin r = chroma; g = x;      b = 0;      end
					1: begin r = x;      g = chroma; b = 0;      end
					2: begin r = 0;      g = chroma; b = x;      end
					3: begin r = 0;      g = x;      b = chroma; end
					4: begin r = x;      g = 0;      b = chroma; end
					default: begin r = chroma; g = 0; b = x; end
				endcase
				px.idx   = led % (1 << PIX_W);
				px.red   = (r + m) & 8'hFF;
				px.green = (g + m) & 8'hFF;
				px.blue  = (b + m) & 8'hFF;
				px.last  = (led == LED_COUNT - 1) ? 1 : 0;
				expected_pixels.push_back(px);
			end
			frame_hue = (frame_hue + hue_step % HUE_FULL) % HUE_FULL;
			frames_noted++;
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("pixel word %0d, %s: expected %0d, actual %0d",
					pixels_checked, name, want, got);
				mismatch_count++;
			end
		endfunction

		function void check_pixel(int unsigned idx, int unsigned red, int unsigned green,
			int unsigned blue, int unsigned last);
			pixel_word_t want;
			if (expected_pixels.size() == 0) begin
				$error("pixel word with index %0d arrived with no frame pending", idx);
				mismatch_count++;
				return;
			end
			want = expected_pixels.pop_front();
			compare_field("pixel_index", want.idx, idx);
			compare_field("red", want.red, red);
			compare_field("green", want.green, green);
			compare_field("blue", want.blue, blue);
			compare_field("last_pixel", want.last, last);
			pixels_checked++;
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

endpackage

FILE: bench/tb_top.sv
// top-level bench for the rainbow frame generator: drivers, pixel monitor and run control
`timescale 1ns / 1ps

module tb_top;
	import rhsv_pkg::*;
	import rainbow_frame_sb_pkg::*;

	localparam int SETTLE_CYCLES      = 12;
	localparam int HOLD_CYCLES        = 300;
	localparam int FRAMES_PER_SETTING = 19;
	localparam int RANDOM_SETTINGS    = 8;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic              frame_request;
	logic              out_valid;
	logic              out_ready;
	logic [PIX_W-1:0]  pixel_index;
	logic [7:0]        red;
	logic [7:0]        green;
	logic [7:0]        blue;
	logic              last_pixel;

	bit long_hold_req = 1'b0;
	bit no_idle = 1'b0;
	int settings_count = 0;

	rainbow_frame_scoreboard frame_sb = new();

	rainbow_hsv_led_frame_generator_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.frame_request (frame_request),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_index   (pixel_index),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.last_pixel    (last_pixel)
	);

	always #2 clk = ~clk;

	initial begin
		#4_000_000;
		$display("Verification failed");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(15, 40);
	endfunction

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// steps at and past a full turn are part of the mix
	function automatic logic [STEP_W-1:0] pick_step();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return STEP_W'(HUE_FULL - 1);
			2: return STEP_W'(HUE_FULL);
			3: return '1;
			4, 5: return STEP_W'($urandom_range(1, 4095));
			default: return STEP_W'($urandom_range(0, (1 << STEP_W) - 1));
		endcase
	endfunction

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		frame_sb.write_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic send_word(input logic request, input bit allow_gap);
		int gap;
		in_valid      <= 1'b1;
		frame_request <= request;
		do @(posedge clk); while (!in_ready);
		frame_sb.note_word(request);
		gap = allow_gap ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid      <= 1'b0;
			frame_request <= 1'($urandom_range(0, 1));
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frames(input int frames);
		repeat (frames) send_word(1'b1, 1'b1);
		in_valid <= 1'b0;
	endtask

	// frames with a stray idle request now and then
	task automatic run_frames(input int frames, input bit allow_gap);
		for (int f = 0; f < frames; f++) begin
			if ($urandom_range(0, 9) == 0)
				send_word(1'b0, allow_gap);
			send_word(1'b1, allow_gap);
		end
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (frame_sb.pending() != 0) @(posedge clk);
	endtask

	// an idle request gives no pixel, so give the pipeline time to empty too
	task automatic settle_idle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic change_setting();
		int pick;
		pick = $urandom_range(1, 7);
		if (pick[0])
			write_reg(REG_SATURATION, pick_level());
		if (pick[1])
			write_reg(REG_BRIGHTNESS, pick_level());
		if (pick[2])
			write_reg(REG_HUE_STEP, pick_step());
		settings_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			frame_sb.check_pixel(pixel_index, red, green, blue, last_pixel);
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				stall = pick_gap();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		frame_request = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, idle requests mixed in
		send_word(1'b0, 1'b0);
		send_word(1'b1, 1'b0);
		send_word(1'b1, 1'b1);
		send_word(1'b0, 1'b1);
		send_word(1'b1, 1'b0);
		in_valid <= 1'b0;
		settle_idle();

		// no saturation: every led the same gray
		write_reg(REG_SATURATION, 32'd0);
		write_reg(REG_BRIGHTNESS, 32'd255);
		settings_count++;
		send_frames(2);
		settle_idle();

		// full color, frozen offset
		write_reg(REG_SATURATION, 32'd255);
		write_reg(REG_HUE_STEP, 32'd0);
		settings_count++;
		send_frames(2);
		settle_idle();

		write_reg(REG_BRIGHTNESS, 32'd0);
		settings_count++;
		send_frames(1);
		settle_idle();

		write_reg(REG_SATURATION, 32'd128);
		write_reg(REG_BRIGHTNESS, 32'd200);
		write_reg(REG_HUE_STEP, DATA_W'(HUE_FULL - 1));
		settings_count++;
		send_frames(2);
		settle_idle();

		// steps of a full turn and beyond wrap around
		write_reg(REG_HUE_STEP, DATA_W'(HUE_FULL));
		settings_count++;
		send_frames(2);
		settle_idle();

		write_reg(REG_HUE_STEP, DATA_W'((1 << STEP_W) - 1));
		settings_count++;
		send_frames(2);
		settle_idle();

		write_reg(REG_HUE_STEP, DATA_W'(HUE_SECT));
		settings_count++;
		send_frames(2);

		for (int ph = 0; ph < RANDOM_SETTINGS; ph++) begin
			settle_idle();
			change_setting();
			no_idle = (ph == 4);
			if (ph == 2) begin
				// receiver stalls long while words keep coming, so the input backs up
				long_hold_req = 1'b1;
				run_frames(FRAMES_PER_SETTING, 1'b0);
			end else if (ph == 5) begin
				run_frames(FRAMES_PER_SETTING / 2, 1'b1);
				wait_drained();
				run_frames(FRAMES_PER_SETTING / 2, 1'b1);
			end else begin
				run_frames(FRAMES_PER_SETTING, 1'b1);
			end
		end
		no_idle = 1'b0;

		wait_drained();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		$display("run covered %0d frames and %0d idle requests over %0d register settings",
			frame_sb.frames_noted, frame_sb.idle_words, settings_count);
		$display("%0d pixel words checked, %0d mismatches, %0d still owed",
			frame_sb.pixels_checked, frame_sb.mismatch_count, frame_sb.pending());
		if (frame_sb.mismatch_count == 0 && frame_sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
sv/rhsv_pkg.sv
sv/rhsv_regs.sv
sv/rhsv_ctrl.sv
sv/rhsv_dp.sv
sv/rainbow_hsv_led_frame_generator_unit.sv
sv/rhsv_chk.sv
bench/rainbow_frame_sb_pkg.sv
bench/tb_top.sv
